// ===== hdl/gbrl_pkg.sv =====
`default_nettype none

package gbrl_pkg;

    localparam int CP_W    = 21;
    localparam int ADDR_W  = 32;
    localparam int ENTRY_W = 6;
    localparam int COUNT_W = 7;
    localparam int REG_W   = 1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [REG_W-1:0] REG_FONT_READY  = 1'b0;
    localparam logic [REG_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic [CP_W-1:0]   first;
        logic [CP_W-1:0]   last;
        logic [ADDR_W-1:0] base;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } wr_t;

    typedef struct packed {
        logic              covers;
        logic [ADDR_W-1:0] offset;
    } match_t;

endpackage

`default_nettype wire

// ===== hdl/gbrl_if.sv =====
`default_nettype none

interface gbrl_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [gbrl_pkg::ENTRY_W-1:0] entry_index;
    logic [gbrl_pkg::CP_W-1:0]    range_first;
    logic [gbrl_pkg::CP_W-1:0]    range_last;
    logic [gbrl_pkg::ADDR_W-1:0]  range_base;
    logic [gbrl_pkg::CP_W-1:0]    codepoint;
    logic                         new_string;

    modport source (
        output valid, op, entry_index, range_first, range_last, range_base,
               codepoint, new_string,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, range_first, range_last, range_base,
               codepoint, new_string,
        output ready
    );
endinterface

interface gbrl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [gbrl_pkg::ADDR_W-1:0]  record_address;
    logic [gbrl_pkg::ENTRY_W-1:0] hit_entry;

    modport source (
        output valid, found, record_address, hit_entry,
        input  ready
    );
    modport sink (
        input  valid, found, record_address, hit_entry,
        output ready
    );
endinterface

interface gbrl_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [gbrl_pkg::REG_W-1:0]   index;
    logic [gbrl_pkg::COUNT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/gbrl_table.sv =====
`default_nettype none

module gbrl_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic             clk,
    input  wire gbrl_pkg::wr_t    wr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output gbrl_pkg::entry_t      rd_data
);
    import gbrl_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/gbrl_match.sv =====
`default_nettype none

module gbrl_match #(
    parameter int RECORD_BYTES = 24
) (
    input  wire gbrl_pkg::entry_t            entry,
    input  wire logic [gbrl_pkg::CP_W-1:0]   cp,
    output gbrl_pkg::match_t                 result
);
    import gbrl_pkg::*;

    logic [CP_W-1:0] diff;

    assign diff          = cp - entry.first;
    assign result.covers = (entry.first <= cp) && (entry.last >= cp);
    assign result.offset = ADDR_W'(ADDR_W'(diff) * ADDR_W'(RECORD_BYTES));

endmodule

`default_nettype wire

// ===== hdl/glyph_block_range_lookup_unit.sv =====
// glyph block range lookup unit
//
// channels: req takes load and lookup transactions, rsp returns one result
// per lookup, cfg writes font_ready (index 0) and block_count (index 1).
// a load transaction writes one table entry in the cycle it is accepted and
// gives no result. a lookup reads the hinted entry first; on a miss it scans
// the table from entry 0, one entry per cycle through the single table read
// port and the shared range compare / offset multiply unit.
// a lookup goes to ST_HINT, on a hint miss to ST_SCAN, then to ST_RESULT; an
// early miss (font not ready, hint not below the entry count) skips to
// ST_RESULT. a scan covers up to min(block_count, MAX_BLOCKS) entries; req.ready
// is low until the result is registered, so one lookup is worked on at a time.
// the result sits in an output register; the next transaction is accepted
// while it waits, and a following result is held until rsp is free.
// reset clears the hint, font_ready, block_count and the output valid; the
// table holds no valid bits and must be loaded before lookups that use it.
// cfg.ready is always high and a write takes effect at the next edge.
`default_nettype none

module glyph_block_range_lookup_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int RECORD_BYTES = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbrl_req_if.sink   req,
    gbrl_rsp_if.source rsp,
    gbrl_cfg_if.sink   cfg
);
    import gbrl_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = ($clog2(MAX_BLOCKS + 1) > COUNT_W) ?
                           $clog2(MAX_BLOCKS + 1) : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HINT,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t               state_reg;
    logic [ENTRY_W-1:0]   hint_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic [ENTRY_W-1:0]   hit_reg;
    logic                 found_reg;
    logic [ADDR_W-1:0]    offset_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [CP_W-1:0]      cp_reg;
    logic                 font_ready_reg;
    logic [COUNT_W-1:0]   block_count_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_found_reg;
    logic [ADDR_W-1:0]    rsp_address_reg;
    logic [ENTRY_W-1:0]   rsp_hit_reg;

    logic                 req_accept;
    logic                 out_free;
    logic [ENTRY_W-1:0]   hint_eff;
    logic [CNT_W-1:0]     count;
    logic [CNT_W-1:0]     scan_inc;
    logic [IDX_W-1:0]     rd_addr;
    wr_t                  wr;
    entry_t               rd_data;
    match_t               match;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !rsp_valid_reg || rsp.ready;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.found          = rsp_found_reg;
    assign rsp.record_address = rsp_address_reg;
    assign rsp.hit_entry      = rsp_hit_reg;

    assign hint_eff = req.new_string ? '0 : hint_reg;
    assign count    = (CNT_W'(block_count_reg) > CNT_W'(MAX_BLOCKS)) ?
                      CNT_W'(MAX_BLOCKS) : CNT_W'(block_count_reg);
    assign scan_inc = scan_reg + CNT_W'(1);

    assign wr.en         = req_accept && (req.op == OP_LOAD) &&
                           (32'(req.entry_index) < MAX_BLOCKS);
    assign wr.data.first = req.range_first;
    assign wr.data.last  = req.range_last;
    assign wr.data.base  = req.range_base;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: rd_addr = IDX_W'(hint_eff);
            ST_SCAN: rd_addr = scan_inc[IDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    gbrl_table #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (IDX_W'(req.entry_index)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbrl_match #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_match (
        .entry  (rd_data),
        .cp     (cp_reg),
        .result (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_ready_reg  <= 1'b0;
            block_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_FONT_READY:  font_ready_reg  <= cfg.data[0];
                REG_BLOCK_COUNT: block_count_reg <= cfg.data;
                default:         font_ready_reg  <= font_ready_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hint_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_RESULT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept && (req.op == OP_LOOKUP))
                    begin
                        cp_reg   <= req.codepoint;
                        hint_reg <= hint_eff;
                        if (font_ready_reg && (CNT_W'(hint_eff) < count))
                        begin
                            state_reg <= ST_HINT;
                        end
                        else
                        begin
                            found_reg <= 1'b0;
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_HINT:
                begin
                    if (match.covers)
                    begin
                        found_reg  <= 1'b1;
                        hit_reg    <= hint_reg;
                        offset_reg <= match.offset;
                        base_reg   <= rd_data.base;
                        state_reg  <= ST_RESULT;
                    end
                    else
                    begin
                        scan_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (match.covers)
                    begin
                        found_reg  <= 1'b1;
                        hit_reg    <= ENTRY_W'(scan_reg);
                        hint_reg   <= ENTRY_W'(scan_reg);
                        offset_reg <= match.offset;
                        base_reg   <= rd_data.base;
                        state_reg  <= ST_RESULT;
                    end
                    else if (scan_inc >= count)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        scan_reg <= scan_inc;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        rsp_found_reg   <= found_reg;
                        rsp_address_reg <= found_reg ? (base_reg + offset_reg) : '0;
                        rsp_hit_reg     <= found_reg ? hit_reg : '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.record_address == '0 && rsp.hit_entry == '0))
        else $error("miss result carries nonzero fields");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg < count))
        else $error("scan index beyond entry count");

    a_hint_needs_font: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HINT) |-> (font_ready_reg && CNT_W'(hint_reg) < count))
        else $error("hint test without ready font or valid hint");

    a_scan_hit_sets_hint: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && match.covers) |=> (hint_reg == hit_reg && found_reg))
        else $error("scan hit did not update hint");
`endif

endmodule

`default_nettype wire

// ===== dv/glyph_lookup_checker.sv =====
`timescale 1ns / 100ps

module glyph_lookup_checker #(
    parameter int MAX_BLOCKS   = 64,
    parameter int RECORD_BYTES = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbrl_req_if       req,
    gbrl_rsp_if       rsp,
    gbrl_cfg_if       cfg,
    output int        mismatches,
    output int        outstanding
);
    import gbrl_pkg::*;

    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  record_address;
        logic [ENTRY_W-1:0] hit_entry;
    } lookup_result_t;

    entry_t             range_table [MAX_BLOCKS];
    logic [ENTRY_W-1:0] hint;
    logic               font_ready;
    logic [COUNT_W-1:0] block_count;
    lookup_result_t     expected_results [$];
    lookup_result_t     want;

    function automatic logic covers_cp(entry_t e, logic [CP_W-1:0] cp);
        return e.first <= cp && e.last >= cp;
    endfunction

    // updates the hint as a side effect
    function automatic lookup_result_t resolve_codepoint(logic [CP_W-1:0] cp, logic clear_hint);
        lookup_result_t    res;
        int                used;
        int                hit;
        int                i;
        logic [ADDR_W-1:0] offset;
        res = '0;
        hit = -1;
        if (clear_hint)
            hint = '0;
        used = (int'(block_count) < MAX_BLOCKS) ? int'(block_count) : MAX_BLOCKS;
        if (font_ready && int'(hint) < used)
        begin
            if (covers_cp(range_table[hint], cp))
                hit = int'(hint);
            else
            begin
                for (i = 0; i < used; i++)
                begin
                    if (hit < 0 && covers_cp(range_table[i], cp))
                    begin
                        hit  = i;
                        hint = ENTRY_W'(i);
                    end
                end
            end
        end
        if (hit >= 0)
        begin
            offset = (ADDR_W'(cp) - ADDR_W'(range_table[hit].first)) * ADDR_W'(RECORD_BYTES);
            res.found          = 1'b1;
            res.record_address = range_table[hit].base + offset;
            res.hit_entry      = ENTRY_W'(hit);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint        = '0;
            font_ready  = 1'b0;
            block_count = '0;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result transaction: found %0b address %h entry %0d",
                             $time, rsp.found, rsp.record_address, rsp.hit_entry);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        mismatches++;
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, rsp.found);
                    end
                    if (rsp.record_address !== want.record_address)
                    begin
                        mismatches++;
                        $display("%0t: record_address mismatch: expected %h actual %h",
                                 $time, want.record_address, rsp.record_address);
                    end
                    if (rsp.hit_entry !== want.hit_entry)
                    begin
                        mismatches++;
                        $display("%0t: hit_entry mismatch: expected %0d actual %0d",
                                 $time, want.hit_entry, rsp.hit_entry);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FONT_READY)
                    font_ready = cfg.data[0];
                else if (cfg.index == REG_BLOCK_COUNT)
                    block_count = cfg.data;
            end
            if (req.valid && req.ready)
            begin
                if (req.op == OP_LOAD)
                begin
                    if (int'(req.entry_index) < MAX_BLOCKS)
                    begin
                        range_table[req.entry_index].first = req.range_first;
                        range_table[req.entry_index].last  = req.range_last;
                        range_table[req.entry_index].base  = req.range_base;
                    end
                end
                else
                    expected_results.push_back(resolve_codepoint(req.codepoint, req.new_string));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== dv/tb_glyph_block_range_lookup_unit.sv =====
`timescale 1ns / 100ps

module tb_glyph_block_range_lookup_unit;
    import gbrl_pkg::*;

    localparam int MAX_BLOCKS       = 64;
    localparam int RECORD_BYTES     = 24;
    localparam int CP_MAX           = 1114111;
    localparam int RANDOM_ITEMS     = 1800;
    localparam int SETTLE_CYCLES    = 160;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic               op;
        logic [ENTRY_W-1:0] entry_index;
        logic [CP_W-1:0]    first;
        logic [CP_W-1:0]    last;
        logic [ADDR_W-1:0]  base;
        logic [CP_W-1:0]    cp;
        logic               new_string;
    } req_item_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;

    logic [CP_W-1:0]    shadow_first [MAX_BLOCKS];
    logic [CP_W-1:0]    shadow_last  [MAX_BLOCKS];
    logic [COUNT_W-1:0] cur_count;
    int                 cur_entry;
    bit                 steady_send;

    gbrl_req_if req_ch ();
    gbrl_rsp_if rsp_ch ();
    gbrl_cfg_if cfg_ch ();

    glyph_block_range_lookup_unit #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .RECORD_BYTES (RECORD_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    glyph_lookup_checker #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .RECORD_BYTES (RECORD_BYTES)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic req_item_t load_item(int idx, int first, int last, logic [ADDR_W-1:0] base);
        req_item_t it;
        it.op          = OP_LOAD;
        it.entry_index = ENTRY_W'(idx);
        it.first       = CP_W'(first);
        it.last        = CP_W'(last);
        it.base        = base;
        it.cp          = CP_W'($urandom_range(CP_MAX, 0));
        it.new_string  = 1'($urandom_range(1, 0));
        shadow_first[idx] = it.first;
        shadow_last[idx]  = it.last;
        return it;
    endfunction

    function automatic req_item_t random_load(int idx);
        int                first;
        int                last;
        int                r;
        logic [ADDR_W-1:0] base;
        first = $urandom_range(CP_MAX, 0);
        r     = $urandom_range(99, 0);
        if (r < 70)
            last = first + $urandom_range(255, 0);
        else if (r < 85)
            last = first + $urandom_range(65535, 0);
        else if (r < 95)
            last = $urandom_range(CP_MAX, 0);
        else
            last = first;
        if (last > CP_MAX)
            last = CP_MAX;
        base = $urandom();
        // near the top so the address wraps
        if ($urandom_range(9, 0) == 0)
            base = 32'hFFFF_FF00 | ADDR_W'($urandom_range(255, 0));
        return load_item(idx, first, last, base);
    endfunction

    function automatic req_item_t lookup_item(logic [CP_W-1:0] cp, logic new_string);
        req_item_t it;
        it.op          = OP_LOOKUP;
        it.entry_index = ENTRY_W'($urandom_range(63, 0));
        it.first       = CP_W'($urandom_range(CP_MAX, 0));
        it.last        = CP_W'($urandom_range(CP_MAX, 0));
        it.base        = $urandom();
        it.cp          = cp;
        it.new_string  = new_string;
        return it;
    endfunction

    // mostly stays inside one entry, like characters of one script in a string
    function automatic logic [CP_W-1:0] target_cp();
        int used;
        int e;
        used = (int'(cur_count) < MAX_BLOCKS) ? int'(cur_count) : MAX_BLOCKS;
        if (used == 0)
            return CP_W'($urandom_range(CP_MAX, 0));
        if (cur_entry >= used || $urandom_range(9, 0) < 4)
            cur_entry = $urandom_range(used - 1, 0);
        e = cur_entry;
        if (shadow_first[e] > shadow_last[e])
            return CP_W'($urandom_range(CP_MAX, 0));
        return CP_W'($urandom_range(shadow_last[e], shadow_first[e]));
    endfunction

    task automatic send(input req_item_t it);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.op          <= it.op;
        req_ch.entry_index <= it.entry_index;
        req_ch.range_first <= it.first;
        req_ch.range_last  <= it.last;
        req_ch.range_base  <= it.base;
        req_ch.codepoint   <= it.cp;
        req_ch.new_string  <= it.new_string;
        do
            @(posedge clk);
        while (!req_ch.ready);
        gap = steady_send ? 0 : gap_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [COUNT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic font, input logic [COUNT_W-1:0] count);
        settle();
        // upper data bits are don't care for font_ready
        write_reg(REG_FONT_READY, {6'($urandom_range(63, 0)), font});
        write_reg(REG_BLOCK_COUNT, count);
        cur_count = count;
    endtask

    initial
    begin : rsp_sink
        int stall_left;
        int hold_left;
        int taken;
        int cycle;
        stall_left = 0;
        hold_left  = 0;
        taken      = 0;
        cycle      = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                taken++;
                // long hold-off so the block backs up into the request side
                if (taken == 200 || taken == 900)
                    hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (cycle % 3000 >= 500 && $urandom_range(3, 0) == 0)
                    stall_left = gap_len();
            end
        end
    end

    initial
    begin : stimulus
        req_item_t          it;
        int                 i;
        int                 n;
        int                 r;
        int                 phase_len;
        int                 random_items;
        logic               font;
        logic [COUNT_W-1:0] count;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= OP_LOAD;
        req_ch.entry_index <= '0;
        req_ch.range_first <= '0;
        req_ch.range_last  <= '0;
        req_ch.range_base  <= '0;
        req_ch.codepoint   <= '0;
        req_ch.new_string  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_FONT_READY;
        cfg_ch.data        <= '0;
        cur_count   = '0;
        cur_entry   = 0;
        steady_send = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole table is written before any lookup can read it
        for (i = 0; i < MAX_BLOCKS; i++)
        begin
            case (i)
                0:  it = load_item(i, 'h41, 'h5A, 32'h0000_1000);
                1:  it = load_item(i, 'h10FF00, 'h10FFFF, 32'hFFFF_FF00);
                2:  it = load_item(i, 'h500, 'h400, 32'h0000_2000);
                3:  it = load_item(i, 0, 0, 32'h0000_0000);
                63: it = load_item(i, 0, CP_MAX, 32'hFFFF_FFFF);
                default: it = random_load(i);
            endcase
            send(it);
        end

        // font not ready, or empty table
        send(lookup_item(CP_W'('h41), 1'b0));
        set_config(1'b0, 7'd64);
        send(lookup_item(CP_W'('h41), 1'b1));
        send(lookup_item(CP_W'('h10FFFF), 1'b0));
        set_config(1'b1, 7'd0);
        send(lookup_item(CP_W'('h41), 1'b0));

        // full table, hint hits and scans, wrap, inverted range
        set_config(1'b1, 7'd64);
        send(lookup_item(CP_W'('h41), 1'b1));
        send(lookup_item(CP_W'('h5A), 1'b0));
        send(lookup_item(CP_W'('h10FFFF), 1'b0));
        send(lookup_item(CP_W'('h10FF00), 1'b0));
        send(lookup_item(CP_W'('h450), 1'b0));
        send(lookup_item(CP_W'(0), 1'b0));
        send(lookup_item(CP_W'('h10FFFF), 1'b1));
        it = random_load(5);
        it.new_string = 1'b1;
        send(it);
        send(lookup_item(CP_W'('h10FF80), 1'b0));

        // count above table size
        set_config(1'b1, 7'd127);
        send(lookup_item(CP_W'(CP_MAX), 1'b1));
        send(lookup_item(CP_W'(0), 1'b0));

        // hint left beyond a smaller count
        set_config(1'b1, 7'd2);
        send(lookup_item(CP_W'('h41), 1'b0));
        send(lookup_item(CP_W'('h41), 1'b1));
        send(lookup_item(CP_W'('h100), 1'b0));
        set_config(1'b1, 7'd1);
        send(lookup_item(CP_W'('h5A), 1'b0));
        send(lookup_item(CP_W'('h10FFFF), 1'b0));

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            font = ($urandom_range(99, 0) < 85);
            r    = $urandom_range(99, 0);
            if (r < 15)
                count = 7'd64;
            else if (r < 25)
                count = 7'd127;
            else if (r < 30)
                count = 7'd0;
            else if (r < 35)
                count = 7'd1;
            else if (r < 60)
                count = COUNT_W'($urandom_range(8, 2));
            else
                count = COUNT_W'($urandom_range(127, 1));
            set_config(font, count);
            steady_send = ($urandom_range(4, 0) == 0);
            phase_len   = $urandom_range(200, 60);
            for (n = 0; n < phase_len; n++)
            begin
                r = $urandom_range(99, 0);
                if (r < 15)
                    it = random_load($urandom_range(63, 0));
                else if (r < 22)
                    it = lookup_item(CP_W'($urandom_range(CP_MAX, 0)), 1'($urandom_range(1, 0)));
                else
                    it = lookup_item(target_cp(), ($urandom_range(9, 0) == 0));
                send(it);
                random_items++;
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gbrl_pkg.sv
hdl/gbrl_if.sv
hdl/gbrl_table.sv
hdl/gbrl_match.sv
hdl/glyph_block_range_lookup_unit.sv
dv/glyph_lookup_checker.sv
dv/tb_glyph_block_range_lookup_unit.sv
